// ===== rtl/impq_pkg.sv =====
// ----------------------------------------------------------------------------
// impq_pkg
// shared constants and types for the indexed minimum priority queue
// ----------------------------------------------------------------------------
package impq_pkg;

    localparam int Capacity  = 256;
    localparam int AddrWidth = $clog2(Capacity);
    localparam int CntWidth  = AddrWidth + 1;

    typedef enum logic [1:0] {
        STATUS_DONE      = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_NOT_FOUND = 2'd2,
        STATUS_DUPLICATE = 2'd3
    } status_t;

    typedef enum logic {
        FUNC_INSERT = 1'b0,
        FUNC_REMOVE = 1'b1
    } func_t;

    typedef struct packed {
        logic        func;
        logic [15:0] edge_id;
        logic [31:0] cost;
        logic [31:0] payload_tag;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [8:0]  count;
        logic        head_valid;
        logic [15:0] head_edge;
        logic [31:0] head_cost;
        logic [31:0] head_payload;
    } rsp_t;

    typedef struct packed {
        logic [15:0] edge_id;
        logic [31:0] cost;
        logic [31:0] payload;
    } entry_t;

endpackage

// ===== rtl/impq_if.sv =====
// ----------------------------------------------------------------------------
// impq_req_if / impq_rsp_if
// valid/ready channels for requests and results
// ----------------------------------------------------------------------------
interface impq_req_if;
    import impq_pkg::*;
    logic valid;
    logic ready;
    req_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface impq_rsp_if;
    import impq_pkg::*;
    logic valid;
    logic ready;
    rsp_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/indexed_min_priority_queue.sv =====
// ----------------------------------------------------------------------------
// indexed_min_priority_queue
// cost-ordered queue with removal by edge index, held in one sorted memory
// ----------------------------------------------------------------------------
// channel | dir | transaction
// req     | in  | insert (edge_id, cost, payload_tag) or remove by edge_id
// rsp     | out | status, count, head entry
//
// one memory read per cycle while scanning: every slot below the count is read,
// then a duplicate, full or not-found request goes straight to the head read,
// else slots shift with a read and a write per moved slot; the sorted chain lives
// in one synchronous ram; the head entry is read back from slot 0 before the result
// reset clears the count, not the memory; slots past the count are not scanned, and
// slot 0 is read even when empty but the head is then masked; a result waits in
// the output register until taken; next request waits too
module indexed_min_priority_queue
    import impq_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    impq_req_if.sink     req,
    impq_rsp_if.source   rsp
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT,
        S_HEAD,
        S_OUT
    } state_t;

    entry_t mem [Capacity];

    state_t               state_reg;
    req_t                 cmd_reg;
    logic [CntWidth-1:0]  cnt_reg;
    logic [CntWidth-1:0]  idx_reg;
    logic [CntWidth-1:0]  ins_reg;
    logic                 ins_found_reg;
    logic [CntWidth-1:0]  pos_reg;
    logic                 pos_found_reg;
    logic                 rd_pend_reg;
    logic [AddrWidth-1:0] rd_addr_reg;
    entry_t               rd_data_reg;
    logic [CntWidth-1:0]  sidx_reg;
    entry_t               head_reg;
    logic [1:0]           status_reg;
    rsp_t                 rsp_out;

    logic                 rd_en;
    logic [AddrWidth-1:0] rd_addr;
    logic                 wr_en;
    logic [AddrWidth-1:0] wr_addr;
    entry_t               wr_data;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // read issue: scan reads idx, shift reads the neighbor of sidx, head reads slot 0
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = idx_reg[AddrWidth-1:0];
        if (state_reg == S_SCAN && idx_reg < cnt_reg)
        begin
            rd_en = 1'b1;
        end
        else if (state_reg == S_SHIFT && !rd_pend_reg)
        begin
            rd_en = 1'b1;
            if (cmd_reg.func == FUNC_INSERT)
            begin
                rd_addr = AddrWidth'(sidx_reg - 1'b1);
            end
            else
            begin
                rd_addr = AddrWidth'(sidx_reg + 1'b1);
            end
        end
        else if (state_reg == S_HEAD)
        begin
            rd_en   = 1'b1;
            rd_addr = '0;
        end
    end

    // write: shift step, or final write of new entry
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = sidx_reg[AddrWidth-1:0];
        wr_data = rd_data_reg;
        if (state_reg == S_SHIFT && rd_pend_reg)
        begin
            wr_en = 1'b1;
        end
        else if (state_reg == S_SHIFT && cmd_reg.func == FUNC_INSERT
                 && sidx_reg == ins_reg)
        begin
            wr_en   = 1'b1;
            wr_data = '{cmd_reg.edge_id, cmd_reg.cost, cmd_reg.payload_tag};
        end
    end

    assign req.ready = (state_reg == S_IDLE);
    assign rsp.valid = (state_reg == S_OUT);
    assign rsp.data  = rsp_out;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            idx_reg       <= '0;
            ins_reg       <= '0;
            ins_found_reg <= 1'b0;
            pos_reg       <= '0;
            pos_found_reg <= 1'b0;
            rd_pend_reg   <= 1'b0;
            rd_addr_reg   <= '0;
            sidx_reg      <= '0;
            status_reg    <= STATUS_DONE;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req.valid)
                    begin
                        cmd_reg       <= req.data;
                        idx_reg       <= '0;
                        ins_found_reg <= 1'b0;
                        pos_found_reg <= 1'b0;
                        rd_pend_reg   <= 1'b0;
                        state_reg     <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    // check data read last cycle
                    if (rd_pend_reg)
                    begin
                        if (!pos_found_reg && rd_data_reg.edge_id == cmd_reg.edge_id)
                        begin
                            pos_found_reg <= 1'b1;
                            pos_reg       <= CntWidth'(rd_addr_reg);
                        end
                        if (!ins_found_reg && rd_data_reg.cost > cmd_reg.cost)
                        begin
                            ins_found_reg <= 1'b1;
                            ins_reg       <= CntWidth'(rd_addr_reg);
                        end
                    end
                    rd_pend_reg <= rd_en;
                    rd_addr_reg <= rd_addr;
                    if (rd_en)
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                    else
                    begin
                        state_reg <= S_DECIDE;
                    end
                end
                S_DECIDE:
                begin
                    rd_pend_reg <= 1'b0;
                    status_reg  <= STATUS_DONE;
                    if (cmd_reg.func == FUNC_INSERT)
                    begin
                        if (pos_found_reg)
                        begin
                            status_reg <= STATUS_DUPLICATE;
                            state_reg  <= S_HEAD;
                        end
                        else if (cnt_reg == CntWidth'(Capacity))
                        begin
                            status_reg <= STATUS_FULL;
                            state_reg  <= S_HEAD;
                        end
                        else
                        begin
                            if (!ins_found_reg)
                            begin
                                ins_reg <= cnt_reg;
                            end
                            sidx_reg  <= cnt_reg;
                            state_reg <= S_SHIFT;
                        end
                    end
                    else
                    begin
                        if (!pos_found_reg)
                        begin
                            status_reg <= STATUS_NOT_FOUND;
                            state_reg  <= S_HEAD;
                        end
                        else
                        begin
                            sidx_reg  <= pos_reg;
                            state_reg <= S_SHIFT;
                        end
                    end
                end
                S_SHIFT:
                begin
                    if (cmd_reg.func == FUNC_INSERT)
                    begin
                        if (rd_pend_reg)
                        begin
                            rd_pend_reg <= 1'b0;
                            sidx_reg    <= sidx_reg - 1'b1;
                        end
                        else if (sidx_reg == ins_reg)
                        begin
                            cnt_reg   <= cnt_reg + 1'b1;
                            state_reg <= S_HEAD;
                        end
                        else
                        begin
                            rd_pend_reg <= 1'b1;
                        end
                    end
                    else
                    begin
                        if (rd_pend_reg)
                        begin
                            rd_pend_reg <= 1'b0;
                            sidx_reg    <= sidx_reg + 1'b1;
                        end
                        else if (sidx_reg + 1'b1 >= cnt_reg)
                        begin
                            cnt_reg   <= cnt_reg - 1'b1;
                            state_reg <= S_HEAD;
                        end
                        else
                        begin
                            rd_pend_reg <= 1'b1;
                        end
                    end
                end
                S_HEAD:
                begin
                    rd_pend_reg <= 1'b1;
                    if (rd_pend_reg)
                    begin
                        head_reg  <= rd_data_reg;
                        state_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (rsp.ready)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    always_comb
    begin
        rsp_out.status       = status_reg;
        rsp_out.count        = 9'(cnt_reg);
        rsp_out.head_valid   = (cnt_reg != '0);
        rsp_out.head_edge    = (cnt_reg != '0) ? head_reg.edge_id : '0;
        rsp_out.head_cost    = (cnt_reg != '0) ? head_reg.cost : '0;
        rsp_out.head_payload = (cnt_reg != '0) ? head_reg.payload : '0;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CntWidth'(Capacity))
        else $error("count above capacity");
    assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && state_reg != S_SHIFT))
        else $error("write outside shift");
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && !rsp.ready) |=> state_reg == S_OUT && $stable(cnt_reg))
        else $error("result lost");
    assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> state_reg == S_SCAN)
        else $error("accept did not start scan");

endmodule
